[rtl/core/sms_pkg.sv]
// Shared widths, constants and register indexes for the shadow map sampler.
// No dependencies; every other file of the block uses it.
`default_nettype none
package sms_pkg;
  localparam int MAX_SIDE        = 256;
  localparam int MAX_RADIUS      = 7;
  localparam int DEPTH_FRAC_BITS = 16;
  localparam int DEPTH_W         = DEPTH_FRAC_BITS + 1;
  localparam int ADDR_W          = 16;
  localparam int SIDE_W          = 9;
  localparam int RAD_W           = 3;
  localparam int ACT_W           = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 17;
  localparam int LIGHT_W         = 16;
  localparam int CNT_W           = 8;
  localparam int DIV_NUM_W       = CNT_W + DEPTH_FRAC_BITS;

  localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1 << DEPTH_FRAC_BITS);

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE   = 3'd0,
    ACT_CLEAR   = 3'd1,
    ACT_NEAREST = 3'd2,
    ACT_PCF     = 3'd3,
    ACT_PCSS    = 3'd4
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH   = 3'd0,
    REG_MAP_HEIGHT  = 3'd1,
    REG_DEPTH_BIAS  = 3'd2,
    REG_PCF_RADIUS  = 3'd3,
    REG_LIGHT_SIZE  = 3'd4,
    REG_BLOCKER_RAD = 3'd5,
    REG_MIN_FILTER  = 3'd6,
    REG_MAX_FILTER  = 3'd7
  } cfg_reg_t;
endpackage
`default_nettype wire

[rtl/core/sms_if.sv]
// Handshake interfaces of the sampler: input items, results, register writes.
// Depends on sms_pkg.
`default_nettype none
interface sms_in_if;
  logic                           valid;
  logic                           ready;
  logic [sms_pkg::ACT_W-1:0]      action;
  logic [sms_pkg::ADDR_W-1:0]     pixel_index;
  logic [sms_pkg::DEPTH_W-1:0]    new_depth;
  logic [sms_pkg::DEPTH_W-1:0]    query_depth;
  logic [sms_pkg::DEPTH_W-1:0]    coord_u;
  logic [sms_pkg::DEPTH_W-1:0]    coord_v;
  modport source (output valid, action, pixel_index, new_depth, query_depth, coord_u,
                  coord_v, input ready);
  modport sink (input valid, action, pixel_index, new_depth, query_depth, coord_u,
                coord_v, output ready);
endinterface

interface sms_out_if;
  logic                        valid;
  logic                        ready;
  logic [sms_pkg::DEPTH_W-1:0] result_value;
  modport source (output valid, result_value, input ready);
  modport sink (input valid, result_value, output ready);
endinterface

interface sms_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sms_pkg::CFG_IDX_W-1:0]  index;
  logic [sms_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/shadow_map_pcf_pcss_sampler.sv]
// Top level of the shadow map sampler: sequencer, shared multiplier, registers.
// Depends on sms_pkg, sms_if, sms_depth_mem, sms_div.
//
//   channel | dir | fields
//   in_ch   | in  | action, pixel_index, new_depth, query_depth, coord_u, coord_v
//   out_ch  | out | result_value
//   cfg_ch  | in  | index, data
//
// Write: multiply, write. Nearest: centre X, centre Y, dispatch, multiply, read,
// data, result. Unused action: back to idle. PCF: the same centring, a window scan
// (off-map pixel: check; in-map: check, address, data), scan end, divide, result (at
// once if the window is empty). PCSS: blocker scan, up to 8 radius steps, PCF scan.
// Clear, reset and a width or height write sweep all 65536 map words; no item taken.
// A result waits in the output register; a new item is taken once it is loaded.
// in_ch.ready is low while a register write is offered.
`default_nettype none
module shadow_map_pcf_pcss_sampler (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sms_in_if.sink     in_ch,
  sms_out_if.source  out_ch,
  sms_cfg_if.sink    cfg_ch
);
  localparam int DW  = sms_pkg::DEPTH_W;
  localparam int AW  = sms_pkg::ADDR_W;
  localparam int SW  = sms_pkg::SIDE_W;
  localparam int RW  = sms_pkg::RAD_W;
  localparam int CW  = sms_pkg::CNT_W;
  localparam int MW  = 25;
  localparam int PW  = 2 * MW;
  localparam int SUMW = 25;
  localparam int ACCW = SUMW + sms_pkg::DEPTH_FRAC_BITS + 3;
  localparam int CENW = SW + sms_pkg::DEPTH_FRAC_BITS;

  typedef enum logic [20:0] {
    S_IDLE      = 21'h000001,
    S_CLEAR     = 21'h000002,
    S_WR_MUL    = 21'h000004,
    S_WR_DO     = 21'h000008,
    S_CEN_X     = 21'h000010,
    S_CEN_Y     = 21'h000020,
    S_DISPATCH  = 21'h000040,
    S_NEAR_MUL  = 21'h000080,
    S_NEAR_RD   = 21'h000100,
    S_NEAR_DATA = 21'h000200,
    S_P_CHECK   = 21'h000400,
    S_P_ADDR    = 21'h000800,
    S_P_DATA    = 21'h001000,
    S_SCAN_END  = 21'h002000,
    S_DIV       = 21'h004000,
    S_K_QS      = 21'h008000,
    S_K_LW      = 21'h010000,
    S_K_NUM     = 21'h020000,
    S_K_NUMR    = 21'h040000,
    S_K_LOOP    = 21'h080000,
    S_RESULT    = 21'h100000
  } state_t;

  state_t state_r, state_nxt;

  logic [SW-1:0]   map_width_r, map_height_r;
  logic [DW-1:0]   depth_bias_r;
  logic [RW-1:0]   pcf_radius_r, blocker_radius_r, min_filter_r, max_filter_r;
  logic [sms_pkg::LIGHT_W-1:0] light_size_r;

  logic [sms_pkg::ACT_W-1:0] act_r;
  logic [AW-1:0]   idx_r;
  logic [DW-1:0]   nd_r, q_r, u_r, v_r;
  logic [AW-1:0]   clr_r;
  logic [SW-1:0]   cx_r, cy_r;
  logic [RW-1:0]   rad_r;
  logic signed [3:0] dx_r, dy_r;
  logic            filt_r;
  logic [CW-1:0]   count_r, hits_r;
  logic [SUMW-1:0] sum_r, diff_r;
  logic [PW-1:0]   mul_r, num_r;
  logic [ACCW-1:0] acc_r;
  logic [RW-1:0]   k_r;
  logic [DW-1:0]   res_r;
  logic            out_valid_r;
  logic [DW-1:0]   out_data_r;

  logic [MW-1:0]   mul_a, mul_b;
  logic [SW-1:0]   w_eff, h_eff, xn, yn;
  logic signed [SW+1:0] xs, ys;
  logic            in_map, last_pix, blocker, start_scan;
  logic [RW-1:0]   scan_rad, r_lo, r_fin;
  logic signed [3:0] rad_s;
  logic signed [DW+1:0] qb;
  logic [DW-1:0]   rdata;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [DW-1:0]   mem_wdata;
  logic [CENW-1:0] cen_sum;
  logic            div_start, div_done;
  logic [DW-1:0]   div_quot;
  logic [SUMW-1:0] qs;
  logic            in_acc;

  always_comb begin
    w_eff = (map_width_r == '0) ? SW'(1) :
            (map_width_r > SW'(sms_pkg::MAX_SIDE)) ? SW'(sms_pkg::MAX_SIDE) : map_width_r;
    h_eff = (map_height_r == '0) ? SW'(1) :
            (map_height_r > SW'(sms_pkg::MAX_SIDE)) ? SW'(sms_pkg::MAX_SIDE) : map_height_r;
    xn = (cx_r > w_eff - 1'b1) ? w_eff - 1'b1 : cx_r;
    yn = (cy_r > h_eff - 1'b1) ? h_eff - 1'b1 : cy_r;
    xs = $signed({2'b00, cx_r}) + (SW+2)'(dx_r);
    ys = $signed({2'b00, cy_r}) + (SW+2)'(dy_r);
    in_map = !xs[SW+1] && (xs[SW:0] < {1'b0, w_eff}) &&
             !ys[SW+1] && (ys[SW:0] < {1'b0, h_eff});
    rad_s = $signed({1'b0, rad_r});
    last_pix = (dx_r == rad_s) && (dy_r == rad_s);
    qb = $signed({2'b00, q_r}) - $signed({2'b00, depth_bias_r});
    blocker = qb > $signed({2'b00, rdata});
    cen_sum = mul_r[CENW-1:0] + CENW'(1 << (sms_pkg::DEPTH_FRAC_BITS - 1));
    qs = mul_r[SUMW-1:0];
    r_lo = (k_r < min_filter_r) ? min_filter_r : k_r;
    r_fin = (r_lo > max_filter_r) ? max_filter_r : r_lo;
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_WR_MUL:   begin mul_a = MW'(w_eff);   mul_b = MW'(h_eff); end
      S_CEN_X:    begin mul_a = MW'(u_r);     mul_b = MW'(w_eff - 1'b1); end
      S_CEN_Y:    begin mul_a = MW'(v_r);     mul_b = MW'(h_eff - 1'b1); end
      S_NEAR_MUL: begin mul_a = MW'(yn);      mul_b = MW'(w_eff); end
      S_P_CHECK:  begin mul_a = MW'(ys[SW-1:0]); mul_b = MW'(w_eff); end
      S_K_QS:     begin mul_a = MW'(q_r);     mul_b = MW'(hits_r); end
      S_K_LW:     begin mul_a = MW'(light_size_r); mul_b = MW'(w_eff); end
      S_K_NUM:    begin mul_a = diff_r;       mul_b = mul_r[MW-1:0]; end
      default:    begin mul_a = '0;           mul_b = '0; end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = nd_r;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = sms_pkg::DEPTH_ONE;
    end else if (state_r == S_WR_DO && ({1'b0, idx_r} < mul_r[AW:0])) begin
      mem_we = 1'b1;
    end
    mem_raddr = (state_r == S_NEAR_RD) ? AW'(mul_r[AW-1:0] + AW'(xn)) :
                AW'(mul_r[AW-1:0] + AW'(xs[SW-1:0]));
  end

  always_comb begin
    state_nxt  = state_r;
    start_scan = 1'b0;
    scan_rad   = rad_r;
    div_start  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.action)
            sms_pkg::ACT_WRITE:   state_nxt = S_WR_MUL;
            sms_pkg::ACT_CLEAR:   state_nxt = S_CLEAR;
            sms_pkg::ACT_NEAREST,
            sms_pkg::ACT_PCF,
            sms_pkg::ACT_PCSS:    state_nxt = S_CEN_X;
            default:              state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLEAR:     if (clr_r == '1) state_nxt = S_IDLE;
      S_WR_MUL:    state_nxt = S_WR_DO;
      S_WR_DO:     state_nxt = S_IDLE;
      S_CEN_X:     state_nxt = S_CEN_Y;
      S_CEN_Y:     state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        if (act_r == sms_pkg::ACT_NEAREST) begin
          state_nxt = S_NEAR_MUL;
        end else begin
          start_scan = 1'b1;
          scan_rad   = (act_r == sms_pkg::ACT_PCF) ? pcf_radius_r : blocker_radius_r;
          state_nxt  = S_P_CHECK;
        end
      end
      S_NEAR_MUL:  state_nxt = S_NEAR_RD;
      S_NEAR_RD:   state_nxt = S_NEAR_DATA;
      S_NEAR_DATA: state_nxt = S_RESULT;
      S_P_CHECK: begin
        if (in_map) state_nxt = S_P_ADDR;
        else if (last_pix) state_nxt = S_SCAN_END;
      end
      S_P_ADDR:    state_nxt = S_P_DATA;
      S_P_DATA:    state_nxt = last_pix ? S_SCAN_END : S_P_CHECK;
      S_SCAN_END: begin
        if (filt_r) begin
          if (count_r == '0) begin
            state_nxt = S_RESULT;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end else if (hits_r == '0) begin
          state_nxt = S_RESULT;
        end else if (sum_r == '0) begin
          start_scan = 1'b1;
          scan_rad   = max_filter_r;
          state_nxt  = S_P_CHECK;
        end else begin
          state_nxt = S_K_QS;
        end
      end
      S_DIV:       if (div_done) state_nxt = S_RESULT;
      S_K_QS:      state_nxt = S_K_LW;
      S_K_LW:      state_nxt = S_K_NUM;
      S_K_NUM:     state_nxt = S_K_NUMR;
      S_K_NUMR:    state_nxt = S_K_LOOP;
      S_K_LOOP: begin
        if ((PW'(acc_r) >= num_r) || (k_r == RW'(sms_pkg::MAX_RADIUS))) begin
          start_scan = 1'b1;
          scan_rad   = r_fin;
          state_nxt  = S_P_CHECK;
        end
      end
      S_RESULT:    if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= PW'(mul_a * mul_b);
    if (state_r == S_IDLE && in_acc) begin
      act_r <= in_ch.action;
      idx_r <= in_ch.pixel_index;
      nd_r  <= in_ch.new_depth;
      q_r   <= in_ch.query_depth;
      u_r   <= in_ch.coord_u;
      v_r   <= in_ch.coord_v;
    end
    if (state_r == S_CEN_Y)    cx_r <= cen_sum[CENW-1:sms_pkg::DEPTH_FRAC_BITS];
    if (state_r == S_DISPATCH) cy_r <= cen_sum[CENW-1:sms_pkg::DEPTH_FRAC_BITS];
    if (start_scan) begin
      rad_r   <= scan_rad;
      dx_r    <= -$signed({1'b0, scan_rad});
      dy_r    <= -$signed({1'b0, scan_rad});
      count_r <= '0;
      hits_r  <= '0;
      sum_r   <= '0;
      filt_r  <= !(state_r == S_DISPATCH && act_r == sms_pkg::ACT_PCSS);
    end else if ((state_r == S_P_CHECK && !in_map && !last_pix) ||
                 (state_r == S_P_DATA && !last_pix)) begin
      if (dx_r == rad_s) begin
        dx_r <= -rad_s;
        dy_r <= dy_r + 1'b1;
      end else begin
        dx_r <= dx_r + 1'b1;
      end
    end
    if (state_r == S_P_DATA) begin
      count_r <= count_r + 1'b1;
      if (blocker) begin
        hits_r <= hits_r + 1'b1;
        sum_r  <= sum_r + SUMW'(rdata);
      end
    end
    if (state_r == S_K_LW)   diff_r <= (qs > sum_r) ? qs - sum_r : '0;
    if (state_r == S_K_NUMR) begin
      num_r <= mul_r;
      acc_r <= '0;
      k_r   <= '0;
    end
    if (state_r == S_K_LOOP) begin
      acc_r <= acc_r + ACCW'({sum_r, {sms_pkg::DEPTH_FRAC_BITS{1'b0}}});
      k_r   <= k_r + 1'b1;
    end
    unique case (state_r)
      S_NEAR_DATA: res_r <= rdata;
      S_SCAN_END:  res_r <= sms_pkg::DEPTH_ONE;
      S_DIV:       res_r <= div_quot;
      default:     res_r <= res_r;
    endcase
    if (state_r == S_RESULT && (!out_valid_r || out_ch.ready)) out_data_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_CLEAR;
      clr_r            <= '0;
      out_valid_r      <= 1'b0;
      map_width_r      <= SW'(256);
      map_height_r     <= SW'(256);
      depth_bias_r     <= DW'(328);
      pcf_radius_r     <= RW'(1);
      light_size_r     <= sms_pkg::LIGHT_W'(655);
      blocker_radius_r <= RW'(2);
      min_filter_r     <= RW'(1);
      max_filter_r     <= RW'(7);
    end else begin
      // a resize restarts the sweep
      if (cfg_ch.valid &&
          (cfg_ch.index inside {sms_pkg::REG_MAP_WIDTH, sms_pkg::REG_MAP_HEIGHT})) begin
        state_r <= S_CLEAR;
        clr_r   <= '0;
      end else begin
        state_r <= state_nxt;
        if (state_r == S_CLEAR) begin
          clr_r <= clr_r + 1'b1;
        end else if (state_r == S_IDLE && in_acc &&
                     in_ch.action == sms_pkg::ACT_CLEAR) begin
          clr_r <= '0;
        end
      end
      if (state_r == S_RESULT && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          sms_pkg::REG_MAP_WIDTH:   map_width_r      <= cfg_ch.data[SW-1:0];
          sms_pkg::REG_MAP_HEIGHT:  map_height_r     <= cfg_ch.data[SW-1:0];
          sms_pkg::REG_DEPTH_BIAS:  depth_bias_r     <= cfg_ch.data[DW-1:0];
          sms_pkg::REG_PCF_RADIUS:  pcf_radius_r     <= cfg_ch.data[RW-1:0];
          sms_pkg::REG_LIGHT_SIZE:  light_size_r     <= cfg_ch.data[sms_pkg::LIGHT_W-1:0];
          sms_pkg::REG_BLOCKER_RAD: blocker_radius_r <= cfg_ch.data[RW-1:0];
          sms_pkg::REG_MIN_FILTER:  min_filter_r     <= cfg_ch.data[RW-1:0];
          sms_pkg::REG_MAX_FILTER:  max_filter_r     <= cfg_ch.data[RW-1:0];
          default: ;
        endcase
      end
    end
  end

  sms_depth_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  sms_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({count_r - hits_r, {sms_pkg::DEPTH_FRAC_BITS{1'b0}}}),
    .den   (count_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_acc              = in_ch.valid && in_ch.ready;
  assign in_ch.ready         = (state_r == S_IDLE) && !cfg_ch.valid;
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_data_r;
endmodule
`default_nettype wire

[rtl/core/sms_depth_mem.sv]
// Depth map storage: one write port, one read port with registered data.
// Depends on sms_pkg.
`default_nettype none
module sms_depth_mem (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [sms_pkg::ADDR_W-1:0]   waddr,
  input  wire logic [sms_pkg::DEPTH_W-1:0]  wdata,
  input  wire logic [sms_pkg::ADDR_W-1:0]   raddr,
  output logic      [sms_pkg::DEPTH_W-1:0]  rdata
);
  logic [sms_pkg::DEPTH_W-1:0] mem [2**sms_pkg::ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/core/sms_div.sv]
// Restoring divider, one quotient bit per cycle, for the visibility ratio.
// Depends on sms_pkg.
`default_nettype none
module sms_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [sms_pkg::DIV_NUM_W-1:0]  num,
  input  wire logic [sms_pkg::CNT_W-1:0]      den,
  output logic                                done,
  output logic      [sms_pkg::DEPTH_W-1:0]    quot
);
  localparam int STEP_W = $clog2(sms_pkg::DIV_NUM_W + 1);

  logic [sms_pkg::DIV_NUM_W-1:0] q_r, q_nxt;
  logic [sms_pkg::CNT_W-1:0]     rem_r, rem_nxt;
  logic [sms_pkg::CNT_W-1:0]     den_r;
  logic [STEP_W-1:0]             step_r;
  logic                          busy_r, done_r;
  logic [sms_pkg::CNT_W:0]       trial;

  always_comb begin
    trial   = {rem_r, q_r[sms_pkg::DIV_NUM_W-1]};
    q_nxt   = {q_r[sms_pkg::DIV_NUM_W-2:0], 1'b0};
    rem_nxt = trial[sms_pkg::CNT_W-1:0];
    if (trial >= {1'b0, den_r}) begin
      rem_nxt  = sms_pkg::CNT_W'(trial - {1'b0, den_r});
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        q_r    <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        q_r    <= q_nxt;
        rem_r  <= rem_nxt;
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(sms_pkg::DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r[sms_pkg::DEPTH_W-1:0];
endmodule
`default_nettype wire
